FILE: sv/mpk_pkg.sv
// msgpack value encoder package: command codes, prefixes and encoded-run type
`timescale 1ns / 1ps
`default_nettype none

package mpk_pkg;

   // command selector carried on tuser
   typedef enum logic [2:0] {
      CMD_INT   = 3'd0,
      CMD_FLOAT = 3'd1,
      CMD_BOOL  = 3'd2,
      CMD_NIL   = 3'd3,
      CMD_STR   = 3'd4,
      CMD_BIN   = 3'd5,
      CMD_CONT  = 3'd6,
      CMD_RAW   = 3'd7
   } cmd_type;

   // widths
   localparam int unsigned VALUE_W   = 32;
   localparam int unsigned CODE_W    = 8;
   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned MAX_BYTES = 5;
   localparam int unsigned COUNT_W   = 3;

   // prefix bytes
   localparam logic [7:0] PFX_INT8    = 8'hd0;
   localparam logic [7:0] PFX_INT16   = 8'hd1;
   localparam logic [7:0] PFX_INT32   = 8'hd2;
   localparam logic [7:0] PFX_FLOAT32 = 8'hca;
   localparam logic [7:0] PFX_TRUE    = 8'hc3;
   localparam logic [7:0] PFX_FALSE   = 8'hc2;
   localparam logic [7:0] PFX_NIL     = 8'hc0;
   localparam logic [7:0] PFX_FIXSTR  = 8'b1010_0000;
   localparam logic [7:0] PFX_STR8    = 8'hd9;
   localparam logic [7:0] PFX_BIN8    = 8'hc4;

   // one encoded run: bytes in stream order from index 0, and how many
   typedef struct packed {
      logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
      logic [COUNT_W-1:0]               count;
   } enc_type;

endpackage

`default_nettype wire

FILE: sv/mpk_encode.sv
// msgpack value encoder: combinational mapping of one command to its byte run
`timescale 1ns / 1ps
`default_nettype none

module mpk_encode (
   input  wire mpk_pkg::cmd_type     cmd,
   input  wire logic [31:0]          value,
   input  wire logic [7:0]           short_code,
   input  wire logic [7:0]           long_code,
   output mpk_pkg::enc_type          enc
);

   // 8/16/32-bit length forms with prefixes base, base+1, base+2
   function automatic mpk_pkg::enc_type sized(input logic [7:0] base, input logic [31:0] len);
      mpk_pkg::enc_type r;
      r = '0;
      if (len[31:8] == 24'd0) begin
         r.bytes[0] = base;
         r.bytes[1] = len[7:0];
         r.count    = 3'd2;
      end else if (len[31:16] == 16'd0) begin
         r.bytes[0] = base + 8'd1;
         r.bytes[1] = len[15:8];
         r.bytes[2] = len[7:0];
         r.count    = 3'd3;
      end else begin
         r.bytes[0] = base + 8'd2;
         r.bytes[1] = len[31:24];
         r.bytes[2] = len[23:16];
         r.bytes[3] = len[15:8];
         r.bytes[4] = len[7:0];
         r.count    = 3'd5;
      end
      return r;
   endfunction

   // signed range tests on the two's complement value
   logic fits_fixint;
   logic fits_int8;
   logic fits_int16;

   assign fits_fixint = (value[31:7] == 25'd0) || (&value[31:5]);
   assign fits_int8   = (value[31:7] == 25'd0) || (&value[31:7]);
   assign fits_int16  = (value[31:15] == 17'd0) || (&value[31:15]);

   // per-command byte run
   always_comb begin
      enc = '0;
      unique case (cmd)
         mpk_pkg::CMD_INT: begin
            if (fits_fixint) begin
               enc.bytes[0] = value[7:0];
               enc.count    = 3'd1;
            end else if (fits_int8) begin
               enc.bytes[0] = mpk_pkg::PFX_INT8;
               enc.bytes[1] = value[7:0];
               enc.count    = 3'd2;
            end else if (fits_int16) begin
               enc.bytes[0] = mpk_pkg::PFX_INT16;
               enc.bytes[1] = value[15:8];
               enc.bytes[2] = value[7:0];
               enc.count    = 3'd3;
            end else begin
               enc.bytes[0] = mpk_pkg::PFX_INT32;
               enc.bytes[1] = value[31:24];
               enc.bytes[2] = value[23:16];
               enc.bytes[3] = value[15:8];
               enc.bytes[4] = value[7:0];
               enc.count    = 3'd5;
            end
         end
         mpk_pkg::CMD_FLOAT: begin
            enc.bytes[0] = mpk_pkg::PFX_FLOAT32;
            enc.bytes[1] = value[31:24];
            enc.bytes[2] = value[23:16];
            enc.bytes[3] = value[15:8];
            enc.bytes[4] = value[7:0];
            enc.count    = 3'd5;
         end
         mpk_pkg::CMD_BOOL: begin
            enc.bytes[0] = (value != 32'd0) ? mpk_pkg::PFX_TRUE : mpk_pkg::PFX_FALSE;
            enc.count    = 3'd1;
         end
         mpk_pkg::CMD_NIL: begin
            enc.bytes[0] = mpk_pkg::PFX_NIL;
            enc.count    = 3'd1;
         end
         mpk_pkg::CMD_STR: begin
            if (value[31:5] == 27'd0) begin
               enc.bytes[0] = mpk_pkg::PFX_FIXSTR | {3'd0, value[4:0]};
               enc.count    = 3'd1;
            end else begin
               enc = sized(mpk_pkg::PFX_STR8, value);
            end
         end
         mpk_pkg::CMD_BIN: begin
            enc = sized(mpk_pkg::PFX_BIN8, value);
         end
         mpk_pkg::CMD_CONT: begin
            if (value[31:4] == 28'd0) begin
               enc.bytes[0] = short_code | {4'd0, value[3:0]};
               enc.count    = 3'd1;
            end else if (value[31:16] == 16'd0) begin
               enc.bytes[0] = long_code;
               enc.bytes[1] = value[15:8];
               enc.bytes[2] = value[7:0];
               enc.count    = 3'd3;
            end else begin
               enc.bytes[0] = long_code + 8'd1;
               enc.bytes[1] = value[31:24];
               enc.bytes[2] = value[23:16];
               enc.bytes[3] = value[15:8];
               enc.bytes[4] = value[7:0];
               enc.count    = 3'd5;
            end
         end
         mpk_pkg::CMD_RAW: begin
            enc.bytes[0] = value[7:0];
            enc.count    = 3'd1;
         end
         default: begin
            enc = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: sv/msgpack_value_encoder.sv
// msgpack value encoder top level: input register, encoder, byte serializer
//
//  channel | dir | handshake          | payload
//  req     | in  | req_tvalid/tready  | tuser: cmd; tdata: value, short_code, long_code
//  rsp     | out | rsp_tvalid/tready  | tdata: out_byte; tlast: last
//
//  one output byte per cycle while rsp_tready is high; an item has 1 to 5 encoded bytes,
//  sent in order by the byte-wide serializer stage
//  an accepted item reaches rsp through the input register and then the serializer register
//  reset is synchronous and clears both stage valid flags
//  a stalled rsp side holds the current byte; one item waits in the input register meanwhile
`timescale 1ns / 1ps
`default_nettype none

module msgpack_value_encoder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,   // value [31:0], short_code [39:32], long_code [47:40]
   input  wire logic [2:0]  req_tuser,   // cmd [2:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // out_byte [7:0]
   output logic             rsp_tlast
);

   // input register
   logic             in_valid_ff;
   mpk_pkg::cmd_type cmd_ff;
   logic [31:0]      value_ff;
   logic [7:0]       short_ff;
   logic [7:0]       long_ff;

   // serializer register
   logic             out_valid_ff, out_valid_in;
   mpk_pkg::enc_type run_ff, run_in;
   logic [2:0]       index_ff, index_in;

   mpk_pkg::enc_type enc;
   logic             req_fire;
   logic             rsp_fire;
   logic             run_done;
   logic             load_run;

   // encoder
   mpk_encode u_encode (
      .cmd        (cmd_ff),
      .value      (value_ff),
      .short_code (short_ff),
      .long_code  (long_ff),
      .enc        (enc)
   );

   // handshake
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = run_ff.bytes[index_ff];
   assign rsp_tlast  = (index_ff == (run_ff.count - 3'd1));
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign run_done   = rsp_fire && rsp_tlast;
   assign load_run   = in_valid_ff && (!out_valid_ff || run_done);
   assign req_tready = !in_valid_ff || load_run;
   assign req_fire   = req_tvalid && req_tready;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_fire) begin
         in_valid_ff <= 1'b1;
      end else if (load_run) begin
         in_valid_ff <= 1'b0;
      end
      if (req_fire) begin
         cmd_ff   <= mpk_pkg::cmd_type'(req_tuser);
         value_ff <= req_tdata[31:0];
         short_ff <= req_tdata[39:32];
         long_ff  <= req_tdata[47:40];
      end
   end

   // serializer next state
   always_comb begin
      out_valid_in = out_valid_ff;
      run_in       = run_ff;
      index_in     = index_ff;
      if (load_run) begin
         out_valid_in = 1'b1;
         run_in       = enc;
         index_in     = 3'd0;
      end else if (run_done) begin
         out_valid_in = 1'b0;
      end else if (rsp_fire) begin
         index_in = index_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      run_ff   <= run_in;
      index_ff <= index_in;
   end

   // checks
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (run_ff.count != 3'd0) && (run_ff.count <= 3'd5))
      else $error("encoded run length out of range");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (index_ff < run_ff.count))
      else $error("serializer index past end of run");

   a_hold_item: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !load_run) |=> in_valid_ff && $stable(value_ff))
      else $error("pending item lost before serializer took it");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && !rsp_tlast) |=> out_valid_ff && (index_ff == $past(index_ff) + 3'd1))
      else $error("run ended before its last word");

endmodule

`default_nettype wire
